[sv/g3lb_pkg.sv]
// Shared types, constants and arithmetic helpers for the 3x3 Gaussian line-buffer filter.
// Stand-alone package: no dependencies.
`default_nettype none

package g3lb_pkg;

    // Pixel layout: three 8-bit channels, channel 0 in the low bits
    localparam int NUM_CHAN = 3;
    localparam int CHAN_W   = 8;

    // Vertical 1-2-1 sum of one channel fits 10 bits, full 3x3 sum fits 12 bits
    localparam int VSUM_W    = 10;
    localparam int HSUM_W    = 12;
    localparam int SUM_SHIFT = 4;

    // Line width register
    localparam int                  LINE_WIDTH_W     = 11;
    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 11'd258;
    localparam int                  MIN_LINE         = 3;

    // Rows needed above the current one before a result is produced
    localparam logic [1:0] ROWS_FULL = 2'd2;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;
    typedef logic [NUM_CHAN-1:0][VSUM_W-1:0] vsum_t;

    // Column sum with weights 1, 2, 1 (top, middle, bottom), per channel
    function automatic vsum_t vert_sum(pixel_t top, pixel_t mid, pixel_t bot);
        vsum_t res;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            res[c] = VSUM_W'(top[c]) + (VSUM_W'(mid[c]) << 1) + VSUM_W'(bot[c]);
        end
        return res;
    endfunction

    // Row of column sums with weights 1, 2, 1, scaled down by 16, per channel
    function automatic pixel_t horiz_filter(vsum_t left, vsum_t centre, vsum_t right);
        pixel_t             res;
        logic [HSUM_W-1:0]  sum;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            sum    = HSUM_W'(left[c]) + (HSUM_W'(centre[c]) << 1) + HSUM_W'(right[c]);
            res[c] = sum[SUM_SHIFT +: CHAN_W];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/gaussian_3x3_rgb_line_buffer_filter_unit.sv]
// Top level of the 3x3 Gaussian blur over a raster-order RGB pixel stream.
// Holds two line stores in synchronous RAM; depends on g3lb_pkg.
//
// Channel   | Ports                                   | Direction | Handshake
// ----------+-----------------------------------------+-----------+------------------
// pixel in  | chan0_in, chan1_in, chan2_in            | in        | in_valid/in_stall
// pixel out | chan0_out, chan1_out, chan2_out         | out       | out_valid/out_stall
// config    | line_width_wdata                        | in        | line_width_we
//
// One pixel per clock sustained while the output is not stalled; each result passes the
// registered line-store read (stage 1) and then the output register before it can leave.
// Reset clears counters, fill marks, valids and column sums and loads the line width;
// the RAMs are not swept, a column beyond a store's fill mark reads as zero, so the block
// accepts pixels straight after reset. An output stall while out_valid is high freezes the
// whole pipeline; in_stall follows it in the same cycle.
`default_nettype none

module gaussian_3x3_rgb_line_buffer_filter_unit #(
    parameter int MAX_LINE = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration
    input  wire logic                             line_width_we,
    input  wire logic [g3lb_pkg::LINE_WIDTH_W-1:0] line_width_wdata,
    // pixel input
    input  wire logic                             in_valid,
    output      logic                             in_stall,
    input  wire logic [g3lb_pkg::CHAN_W-1:0]      chan0_in,
    input  wire logic [g3lb_pkg::CHAN_W-1:0]      chan1_in,
    input  wire logic [g3lb_pkg::CHAN_W-1:0]      chan2_in,
    // pixel output
    output      logic                             out_valid,
    input  wire logic                             out_stall,
    output      logic [g3lb_pkg::CHAN_W-1:0]      chan0_out,
    output      logic [g3lb_pkg::CHAN_W-1:0]      chan1_out,
    output      logic [g3lb_pkg::CHAN_W-1:0]      chan2_out
);

    // Column index, fill mark and width-compare widths
    localparam int CW  = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int FW  = $clog2(MAX_LINE + 1);
    localparam int WW  = (FW > g3lb_pkg::LINE_WIDTH_W) ? FW : g3lb_pkg::LINE_WIDTH_W;

    localparam logic [WW-1:0] MAX_W = WW'(MAX_LINE);
    localparam logic [WW-1:0] MIN_W = WW'(g3lb_pkg::MIN_LINE);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [g3lb_pkg::LINE_WIDTH_W-1:0] line_width_reg;
    logic [CW-1:0]                     column_reg, column_next;
    logic [1:0]                        rows_reg, rows_next;
    logic                              swap_reg;
    logic [FW-1:0]                     fill_a_reg, fill_b_reg;

    logic                              adv;
    logic                              in_accept;
    logic [WW-1:0]                     width_clamped;
    logic [WW-1:0]                     last_col;
    logic                              line_end;
    logic [FW-1:0]                     col_plus_one;
    g3lb_pkg::pixel_t                  px;

    // Stage 1: RAM data arriving
    logic                              s1_valid_reg;
    logic                              s1_emit_reg;
    logic                              s1_swap_reg;
    logic                              s1_a_ok_reg, s1_b_ok_reg;
    g3lb_pkg::pixel_t                  s1_px_reg;

    // Line-store RAMs
    g3lb_pkg::pixel_t                  store_a [MAX_LINE];
    g3lb_pkg::pixel_t                  store_b [MAX_LINE];
    g3lb_pkg::pixel_t                  rd_a_reg, rd_b_reg;

    // Window of vertical sums and output register
    g3lb_pkg::vsum_t                   vcol1_reg, vcol2_reg;
    g3lb_pkg::vsum_t                   vnew;
    g3lb_pkg::pixel_t                  older_px, newer_px;
    g3lb_pkg::pixel_t                  out_px_reg;
    logic                              out_valid_reg;

    // Advance the pipeline whenever the output register is free or being drained
    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign in_accept = in_valid && adv;

    assign px = {chan2_in, chan1_in, chan0_in};

    // Clamp the line width to the supported range
    always_comb
    begin
        width_clamped = WW'(line_width_reg);
        if (width_clamped < MIN_W)
        begin
            width_clamped = MIN_W;
        end
        else if (width_clamped > MAX_W)
        begin
            width_clamped = MAX_W;
        end
    end

    assign last_col     = width_clamped - WW'(1);
    assign line_end     = WW'(column_reg) >= last_col;
    assign col_plus_one = FW'(column_reg) + FW'(1);

    // Column and row tracking
    always_comb
    begin
        column_next = line_end ? '0 : column_reg + CW'(1);
        rows_next   = rows_reg;
        if (line_end && rows_reg != g3lb_pkg::ROWS_FULL)
        begin
            rows_next = rows_reg + 2'd1;
        end
    end

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= g3lb_pkg::LINE_WIDTH_RESET;
        end
        else if (line_width_we)
        begin
            line_width_reg <= line_width_wdata;
        end
    end

    // Advance position, swap store roles at line end, extend fill marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            rows_reg   <= '0;
            swap_reg   <= 1'b0;
            fill_a_reg <= '0;
            fill_b_reg <= '0;
        end
        else if (in_accept)
        begin
            column_reg <= column_next;
            rows_reg   <= rows_next;
            if (line_end)
            begin
                swap_reg <= !swap_reg;
            end
            if (!swap_reg && col_plus_one > fill_a_reg)
            begin
                fill_a_reg <= col_plus_one;
            end
            if (swap_reg && col_plus_one > fill_b_reg)
            begin
                fill_b_reg <= col_plus_one;
            end
        end
    end

    // Store A: write the pixel when A is the older store, read-first
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_a_reg <= store_a[column_reg];
        end
        if (in_accept && !swap_reg)
        begin
            store_a[column_reg] <= px;
        end
    end

    // Store B: write the pixel when B is the older store, read-first
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_b_reg <= store_b[column_reg];
        end
        if (in_accept && swap_reg)
        begin
            store_b[column_reg] <= px;
        end
    end

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_accept;
            s1_emit_reg  <= in_accept && (column_reg >= CW'(2))
                            && (rows_reg == g3lb_pkg::ROWS_FULL);
        end
    end

    // Stage 1 payload: pixel, store roles and entry validity
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_px_reg   <= px;
            s1_swap_reg <= swap_reg;
            s1_a_ok_reg <= FW'(column_reg) < fill_a_reg;
            s1_b_ok_reg <= FW'(column_reg) < fill_b_reg;
        end
    end

    // Select older and newer rows; a never-written entry reads as zero
    always_comb
    begin
        if (s1_swap_reg)
        begin
            older_px = s1_b_ok_reg ? rd_b_reg : '0;
            newer_px = s1_a_ok_reg ? rd_a_reg : '0;
        end
        else
        begin
            older_px = s1_a_ok_reg ? rd_a_reg : '0;
            newer_px = s1_b_ok_reg ? rd_b_reg : '0;
        end
    end

    assign vnew = g3lb_pkg::vert_sum(older_px, newer_px, s1_px_reg);

    // Slide the window of column sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcol1_reg <= '0;
            vcol2_reg <= '0;
        end
        else if (adv && s1_valid_reg)
        begin
            vcol1_reg <= vcol2_reg;
            vcol2_reg <= vnew;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg && s1_emit_reg)
        begin
            out_px_reg <= g3lb_pkg::horiz_filter(vcol1_reg, vcol2_reg, vnew);
        end
    end

    assign out_valid = out_valid_reg;
    assign chan0_out = out_px_reg[0];
    assign chan1_out = out_px_reg[1];
    assign chan2_out = out_px_reg[2];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Row count saturates at full
    a_rows_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rows_reg != 2'd3)
        else $error("row count passed saturation");

    // Fill marks never exceed the store depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_a_reg <= FW'(MAX_LINE)) && (fill_b_reg <= FW'(MAX_LINE)))
        else $error("fill mark beyond store depth");

    // A result in flight implies both previous lines were seen
    a_emit_rows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_emit_reg |-> rows_reg == g3lb_pkg::ROWS_FULL)
        else $error("result scheduled before two lines passed");

    // Store roles change only at the end of a line
    a_swap_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !line_end |=> $stable(swap_reg))
        else $error("store roles swapped mid-line");

    // An accepted pixel reaches stage 1 on the next edge
    a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted pixel lost before stage 1");

endmodule

`default_nettype wire

[verif/g3lb_scoreboard.sv]
// Checker for the 3x3 Gaussian blur unit. It watches the configuration, pixel-in and pixel-out
// channels, predicts each blurred pixel and compares it with the block's output.
// Depends on g3lb_pkg for the pixel type and the line width constants.
`default_nettype none

module g3lb_scoreboard (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              line_width_we,
    input  wire logic [g3lb_pkg::LINE_WIDTH_W-1:0] line_width_wdata,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic [g3lb_pkg::CHAN_W-1:0]       chan0_in,
    input  wire logic [g3lb_pkg::CHAN_W-1:0]       chan1_in,
    input  wire logic [g3lb_pkg::CHAN_W-1:0]       chan2_in,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic [g3lb_pkg::CHAN_W-1:0]       chan0_out,
    input  wire logic [g3lb_pkg::CHAN_W-1:0]       chan1_out,
    input  wire logic [g3lb_pkg::CHAN_W-1:0]       chan2_out,
    output int                                     failures,
    output int                                     results_checked,
    output int                                     pending
);

    localparam int LINE_DEPTH = 1024;
    localparam int KERNEL [3][3] = '{'{1, 2, 1}, '{2, 4, 2}, '{1, 2, 1}};

    // Own copy of the block state
    g3lb_pkg::pixel_t                  store_a [LINE_DEPTH];
    g3lb_pkg::pixel_t                  store_b [LINE_DEPTH];
    g3lb_pkg::pixel_t                  win [3][3];
    logic [9:0]                        col;
    logic [1:0]                        rows;
    logic                              swapped;
    logic [g3lb_pkg::LINE_WIDTH_W-1:0] line_width;

    // Blurred pixels still owed by the block, oldest first
    g3lb_pkg::pixel_t                  blurred_q [$];

    // Slide the window over one pixel, update the line stores and queue any result
    task automatic blur_pixel(input g3lb_pkg::pixel_t px);
        int               eff;
        int               x;
        int               acc;
        g3lb_pkg::pixel_t res;
        eff = line_width;
        if (eff < g3lb_pkg::MIN_LINE)
        begin
            eff = g3lb_pkg::MIN_LINE;
        end
        if (eff > LINE_DEPTH)
        begin
            eff = LINE_DEPTH;
        end
        x = col;
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        // read both stores before the current pixel overwrites the older one
        win[0][2] = swapped ? store_b[x] : store_a[x];
        win[1][2] = swapped ? store_a[x] : store_b[x];
        win[2][2] = px;
        if (swapped)
        begin
            store_b[x] = px;
        end
        else
        begin
            store_a[x] = px;
        end
        if (col >= 2 && rows >= g3lb_pkg::ROWS_FULL)
        begin
            for (int ch = 0; ch < g3lb_pkg::NUM_CHAN; ch++)
            begin
                acc = 0;
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        acc += int'(win[r][c][ch]) * KERNEL[r][c];
                    end
                end
                res[ch] = acc[g3lb_pkg::SUM_SHIFT +: g3lb_pkg::CHAN_W];
            end
            blurred_q.push_back(res);
        end
        // end the line, or advance the column
        if (int'(col) >= eff - 1)
        begin
            col = '0;
            if (rows < g3lb_pkg::ROWS_FULL)
            begin
                rows = rows + 2'd1;
            end
            swapped = ~swapped;
        end
        else
        begin
            col = col + 10'd1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        g3lb_pkg::pixel_t got;
        g3lb_pkg::pixel_t want;
        bit               bad;
        if (!rst_n)
        begin
            for (int i = 0; i < LINE_DEPTH; i++)
            begin
                store_a[i] = '0;
                store_b[i] = '0;
            end
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win[r][c] = '0;
                end
            end
            col             = '0;
            rows            = '0;
            swapped         = 1'b0;
            line_width      = g3lb_pkg::LINE_WIDTH_RESET;
            failures        = 0;
            results_checked = 0;
            blurred_q.delete();
            pending <= 0;
        end
        else
        begin
            // compare the output transaction first: a result never leaves on its input's edge
            if (out_valid && !out_stall)
            begin
                got = {chan2_out, chan1_out, chan0_out};
                if (blurred_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    failures++;
                end
                else
                begin
                    want = blurred_q.pop_front();
                    bad  = 1'b0;
                    for (int ch = 0; ch < g3lb_pkg::NUM_CHAN; ch++)
                    begin
                        if (got[ch] !== want[ch])
                        begin
                            $display("%0t: chan%0d_out expected %0d actual %0d",
                                     $time, ch, want[ch], got[ch]);
                            bad = 1'b1;
                        end
                    end
                    if (bad)
                    begin
                        failures++;
                    end
                    results_checked++;
                end
            end
            // an input transaction on the same edge still sees the old width
            if (in_valid && !in_stall)
            begin
                blur_pixel({chan2_in, chan1_in, chan0_in});
            end
            if (line_width_we)
            begin
                line_width = line_width_wdata;
            end
            pending <= blurred_q.size();
        end
    end

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Top of the Gaussian blur testbench: clock, reset, pixel and line width stimulus, verdict.
// Instantiates the blur unit and g3lb_scoreboard; depends on g3lb_pkg.
`default_nettype none

module tb_top;

    localparam int IDLE_LIMIT   = 2000;
    localparam int NUM_PHASES   = 12;
    localparam int LINE_WIDTH_W = g3lb_pkg::LINE_WIDTH_W;
    localparam int CHAN_W       = g3lb_pkg::CHAN_W;

    logic                    clk              = 1'b0;
    logic                    rst_n            = 1'b0;
    logic                    line_width_we    = 1'b0;
    logic [LINE_WIDTH_W-1:0] line_width_wdata = '0;
    logic                    in_valid         = 1'b0;
    logic [CHAN_W-1:0]       chan0_in         = '0;
    logic [CHAN_W-1:0]       chan1_in         = '0;
    logic [CHAN_W-1:0]       chan2_in         = '0;
    logic                    out_stall        = 1'b0;
    logic                    in_stall;
    logic                    out_valid;
    logic [CHAN_W-1:0]       chan0_out;
    logic [CHAN_W-1:0]       chan1_out;
    logic [CHAN_W-1:0]       chan2_out;

    int failures;
    int results_checked;
    int pending;
    int pixels_sent        = 0;
    int widths_used        = 0;
    int idle_cycles        = 0;
    int sender_gap_pct     = 0;
    int receiver_stall_pct = 0;

    // Three-pixel lines: zero, full-scale and alternating-bit rows, then a mix
    logic [23:0] directed_px [24] = '{
        24'h000000, 24'hFFFFFF, 24'h000000,
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
        24'h000000, 24'h000000, 24'h000000,
        24'hAA55AA, 24'h55AA55, 24'hAA55AA,
        24'h55AA55, 24'hAA55AA, 24'h55AA55,
        24'h010203, 24'hFEFDFC, 24'h804020
    };
    // Widths below 3 and above the store depth clamp; 2047 runs past a full line
    int phase_width [NUM_PHASES] = '{5, 0, 11, 2047, 4, 1, 17, 2, 1024, 7, 3, 64};

    gaussian_3x3_rgb_line_buffer_filter_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .line_width_we    (line_width_we),
        .line_width_wdata (line_width_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .chan0_in         (chan0_in),
        .chan1_in         (chan1_in),
        .chan2_in         (chan2_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .chan0_out        (chan0_out),
        .chan1_out        (chan1_out),
        .chan2_out        (chan2_out)
    );

    g3lb_scoreboard u_scoreboard (
        .clk              (clk),
        .rst_n            (rst_n),
        .line_width_we    (line_width_we),
        .line_width_wdata (line_width_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .chan0_in         (chan0_in),
        .chan1_in         (chan1_in),
        .chan2_in         (chan2_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .chan0_out        (chan0_out),
        .chan1_out        (chan1_out),
        .chan2_out        (chan2_out),
        .failures         (failures),
        .results_checked  (results_checked),
        .pending          (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stall the output channel at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Abort when no transaction of any kind has moved for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || line_width_we)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending);
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one pixel, with an optional random gap first, and hold it until accepted
    task automatic send_pixel(input g3lb_pkg::pixel_t px);
        if ($urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < sender_gap_pct);
        end
        in_valid <= 1'b1;
        chan0_in <= px[0];
        chan1_in <= px[1];
        chan2_in <= px[2];
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pixels_sent++;
    endtask

    // Drop valid and wait until every owed result has left the block
    task automatic drain;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        // border pixels give no result but may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic set_line_width(input logic [LINE_WIDTH_W-1:0] w);
        drain();
        line_width_we    <= 1'b1;
        line_width_wdata <= w;
        @(posedge clk);
        line_width_we    <= 1'b0;
        widths_used++;
    endtask

    initial
    begin
        int               items;
        int               pick;
        g3lb_pkg::pixel_t px;

        sender_gap_pct     = 21;
        receiver_stall_pct = 58;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        set_line_width(LINE_WIDTH_W'(g3lb_pkg::MIN_LINE));
        foreach (directed_px[i])
        begin
            send_pixel(directed_px[i]);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // swap the idling sides after four phases, stop idling after eight
            if (ph == 4)
            begin
                sender_gap_pct     = 58;
                receiver_stall_pct = 21;
            end
            else if (ph == 8)
            begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 0;
            end
            set_line_width(LINE_WIDTH_W'(phase_width[ph]));
            if (phase_width[ph] == 2047)
            begin
                items = 1080;
            end
            else if (phase_width[ph] == 1024)
            begin
                items = 40;
            end
            else
            begin
                items = $urandom_range(50, 90);
            end
            repeat (items)
            begin
                // bias channels towards the extremes now and then
                for (int ch = 0; ch < g3lb_pkg::NUM_CHAN; ch++)
                begin
                    pick = $urandom_range(7);
                    if (pick == 0)
                    begin
                        px[ch] = '0;
                    end
                    else if (pick == 1)
                    begin
                        px[ch] = '1;
                    end
                    else
                    begin
                        px[ch] = CHAN_W'($urandom);
                    end
                end
                send_pixel(px);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Sent %0d pixels over %0d line width settings (clamped extremes included)",
                 pixels_sent, widths_used);
        $display("Checked %0d blurred pixels, %0d with mismatches", results_checked, failures);
        if (failures == 0 && pending == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
sv/g3lb_pkg.sv
sv/gaussian_3x3_rgb_line_buffer_filter_unit.sv
verif/g3lb_scoreboard.sv
verif/tb_top.sv
